@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the blocks that check themselves.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_PROP(lbl, !(expr), msg)

`endif

@@ rtl/core/pbs_pkg.sv @@
package pbs_pkg;

    localparam int DEF_MAX_IMAGE_SIZE = 1024;
    localparam int DEF_MAX_SPLAT_SIZE = 8;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_SIZE = 2'd2;

    localparam logic [10:0] RST_IMAGE_SIZE = 11'd512;
    localparam logic [23:0] RST_SCALE_Q16  = 24'd3355;
    localparam logic [3:0]  RST_POINT_SIZE = 4'd1;

    // height index: floor(255 * (zc + 200) / 500), the /500 as a reciprocal
    localparam int Z_LOW      = -200;
    localparam int Z_HIGH     = 300;
    localparam int Z_SPAN     = 500;
    localparam int HIDX_RECIP = 134218;
    localparam int HIDX_SHIFT = 26;

    // classified points waiting for the splat sequencer
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/core/pbs_front.sv @@
module pbs_front #(
    parameter int MAX_IMAGE_SIZE = pbs_pkg::DEF_MAX_IMAGE_SIZE,
    parameter int MAX_SPLAT_SIZE = pbs_pkg::DEF_MAX_SPLAT_SIZE,
    localparam int AW  = $clog2(MAX_IMAGE_SIZE),
    localparam int SZW = $clog2(MAX_IMAGE_SIZE + 1),
    localparam int PSW = $clog2(MAX_SPLAT_SIZE + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [19:0]  i_point_x,
    input  logic signed [19:0]  i_point_y,
    input  logic signed [19:0]  i_point_z,
    input  logic [SZW-1:0]      i_size,
    input  logic [23:0]         i_scale,
    input  logic [PSW-1:0]      i_half,
    input  pbs_pkg::t_q_status  i_q_stat,
    output logic                o_push,
    output logic [AW-1:0]       o_cx,
    output logic [AW-1:0]       o_cy,
    output logic [7:0]          o_hidx
);
    import pbs_pkg::*;

    localparam logic signed [19:0] ZL = 20'(Z_LOW);
    localparam logic signed [19:0] ZH = 20'(Z_HIGH);
    localparam logic signed [45:0] RND = 46'sd32768;

    logic                r_s1_vld;
    logic signed [19:0]  r_x;
    logic signed [19:0]  r_y;
    logic signed [19:0]  r_z;

    logic                r_s2_vld;
    logic signed [44:0]  r_prod_x;
    logic signed [44:0]  r_prod_y;
    logic [16:0]         r_hv;

    logic signed [44:0]  prod_x;
    logic signed [44:0]  prod_y;
    logic [8:0]          z_off;
    logic [16:0]         hv;
    logic signed [45:0]  half_q16;
    logic signed [45:0]  cx_full;
    logic signed [45:0]  cy_full;
    logic signed [29:0]  cx;
    logic signed [29:0]  cy;
    logic signed [29:0]  lo_lim;
    logic signed [29:0]  hi_lim;
    logic                keep;
    logic [34:0]         hprod;
    logic                s2_leave;
    logic                s2_free;
    logic                s1_free;

    // stage 1 to 2: both projections and the scaled height
    assign prod_x = r_x * $signed({1'b0, i_scale});
    assign prod_y = r_y * $signed({1'b0, i_scale});

    always_comb begin
        if (r_z < ZL) begin
            z_off = '0;
        end else if (r_z > ZH) begin
            z_off = 9'(Z_SPAN);
        end else begin
            z_off = 9'(r_z - ZL);
        end
    end

    assign hv = {z_off, 8'b0} - {8'b0, z_off};

    // stage 2: round half up, take the floor, test the splat against the borders
    assign half_q16 = $signed(46'(i_size) << 15);
    assign cx_full  = half_q16 + 46'(r_prod_y) + RND;
    assign cy_full  = half_q16 - 46'(r_prod_x) + RND;
    assign cx       = $signed(cx_full[45:16]);
    assign cy       = $signed(cy_full[45:16]);
    assign lo_lim   = $signed(30'(i_half));
    assign hi_lim   = $signed(30'(i_size)) - lo_lim;
    assign keep     = (cx >= lo_lim) && (cx < hi_lim) && (cy >= lo_lim) && (cy < hi_lim);

    assign hprod  = r_hv * 18'(HIDX_RECIP);
    assign o_hidx = hprod[HIDX_SHIFT+7:HIDX_SHIFT];
    assign o_cx   = cx[AW-1:0];
    assign o_cy   = cy[AW-1:0];

    // a dropped point leaves without needing room in the queue
    assign o_push   = r_s2_vld && keep && !i_q_stat.full;
    assign s2_leave = r_s2_vld && (!keep || !i_q_stat.full);
    assign s2_free  = !r_s2_vld || s2_leave;
    assign s1_free  = !r_s1_vld || s2_free;
    assign o_stall  = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_valid;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_x <= i_point_x;
            r_y <= i_point_y;
            r_z <= i_point_z;
        end
        if (s2_free && r_s1_vld) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
            r_hv     <= hv;
        end
    end

endmodule

@@ rtl/core/pbs_fifo.sv @@
module pbs_fifo #(
    parameter int W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_data,
    input  logic                i_pop,
    output logic [W-1:0]        o_data,
    output pbs_pkg::t_q_status  o_stat
);
    import pbs_pkg::*;

    localparam int QPW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(Q_DEPTH - 1);

    logic [W-1:0]   r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/core/pbs_back.sv @@
module pbs_back #(
    parameter int MAX_IMAGE_SIZE = pbs_pkg::DEF_MAX_IMAGE_SIZE,
    parameter int MAX_SPLAT_SIZE = pbs_pkg::DEF_MAX_SPLAT_SIZE,
    localparam int AW  = $clog2(MAX_IMAGE_SIZE),
    localparam int SZW = $clog2(MAX_IMAGE_SIZE + 1),
    localparam int PSW = $clog2(MAX_SPLAT_SIZE + 1),
    localparam int CW  = (MAX_SPLAT_SIZE > 1) ? $clog2(MAX_SPLAT_SIZE) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbs_pkg::t_q_status  i_q_stat,
    input  logic [AW-1:0]       i_cx,
    input  logic [AW-1:0]       i_cy,
    input  logic [7:0]          i_hidx,
    output logic                o_pop,
    input  logic [SZW-1:0]      i_size,
    input  logic [PSW-1:0]      i_half,
    input  logic [CW-1:0]       i_ps_last,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [9:0]          o_pixel_col,
    output logic [9:0]          o_pixel_row,
    output logic [19:0]         o_pixel_address,
    output logic [7:0]          o_height_index,
    output logic                o_last_write
);
    import pbs_pkg::*;

    logic             r_gen_vld;
    logic [AW-1:0]    r_col;
    logic [AW-1:0]    r_col0;
    logic [AW-1:0]    r_row;
    logic [CW-1:0]    r_dx;
    logic [CW-1:0]    r_dy;
    logic [7:0]       r_hidx;

    logic             r_out_vld;
    logic [9:0]       r_out_col;
    logic [9:0]       r_out_row;
    logic [19:0]      r_out_addr;
    logic [7:0]       r_out_hidx;
    logic             r_out_last;

    logic             out_ready;
    logic             emit;
    logic             gen_last;
    logic             load_slot;
    logic [AW-1:0]    half_aw;
    logic [AW+SZW-1:0] row_base;
    logic [AW+SZW-1:0] addr_sum;
    logic [31:0]      addr_ext;
    logic [31:0]      col_ext;
    logic [31:0]      row_ext;

    assign out_ready = !r_out_vld || !i_stall;
    assign emit      = r_gen_vld && out_ready;
    assign gen_last  = (r_dx == i_ps_last) && (r_dy == i_ps_last);
    assign load_slot = !r_gen_vld || (emit && gen_last);
    assign o_pop     = load_slot && !i_q_stat.empty;
    assign half_aw   = AW'(i_half);

    assign row_base = r_row * i_size;
    assign addr_sum = row_base + (AW+SZW)'(r_col);
    assign addr_ext = 32'(addr_sum);
    assign col_ext  = 32'(r_col);
    assign row_ext  = 32'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_gen_vld <= 1'b1;
            end else if (load_slot) begin
                r_gen_vld <= 1'b0;
            end
            if (out_ready) begin
                r_out_vld <= r_gen_vld;
            end
        end
    end

    // walk the splat row by row, left to right
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_col  <= i_cx - half_aw;
            r_col0 <= i_cx - half_aw;
            r_row  <= i_cy - half_aw;
            r_dx   <= '0;
            r_dy   <= '0;
            r_hidx <= i_hidx;
        end else if (emit) begin
            if (r_dx == i_ps_last) begin
                r_dx  <= '0;
                r_col <= r_col0;
                r_dy  <= r_dy + 1'b1;
                r_row <= r_row + 1'b1;
            end else begin
                r_dx  <= r_dx + 1'b1;
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_col  <= col_ext[9:0];
            r_out_row  <= row_ext[9:0];
            r_out_addr <= addr_ext[19:0];
            r_out_hidx <= r_hidx;
            r_out_last <= gen_last;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_pixel_col     = r_out_col;
    assign o_pixel_row     = r_out_row;
    assign o_pixel_address = r_out_addr;
    assign o_height_index  = r_out_hidx;
    assign o_last_write    = r_out_last;

endmodule

@@ rtl/core/point_to_bev_pixel_splat.sv @@
// Path: an accepted point passes the front pipeline, the queue, the splat sequencer and the output
// register on its way to its first pixel word. Throughput: one point per cycle in while o_stall is
// low; a kept point holds the sequencer for point_size squared pixel words, one pixel word per
// cycle while i_stall allows; splat area sets the sustained rate. Dropped points produce nothing.
// Reset: synchronous, active low; clears the pipeline, the queue and the sequencer and
// loads image_size 512, scale_q16 3355, point_size 1. No clearing pass.
module point_to_bev_pixel_splat #(
    parameter int MAX_IMAGE_SIZE = pbs_pkg::DEF_MAX_IMAGE_SIZE,
    parameter int MAX_SPLAT_SIZE = pbs_pkg::DEF_MAX_SPLAT_SIZE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [19:0]              i_point_x,
    input  logic signed [19:0]              i_point_y,
    input  logic signed [19:0]              i_point_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [9:0]                      o_pixel_col,
    output logic [9:0]                      o_pixel_row,
    output logic [19:0]                     o_pixel_address,
    output logic [7:0]                      o_height_index,
    output logic                            o_last_write
);
    import pbs_pkg::*;

    localparam int AW  = $clog2(MAX_IMAGE_SIZE);
    localparam int SZW = $clog2(MAX_IMAGE_SIZE + 1);
    localparam int PSW = $clog2(MAX_SPLAT_SIZE + 1);
    localparam int CW  = (MAX_SPLAT_SIZE > 1) ? $clog2(MAX_SPLAT_SIZE) : 1;
    localparam int QW  = 2 * AW + 8;

    logic [10:0]    r_image_size;
    logic [23:0]    r_scale;
    logic [3:0]     r_point_size;

    logic [SZW-1:0] size;
    logic [PSW-1:0] ps;
    logic [PSW-1:0] half;
    logic [CW-1:0]  ps_last;

    t_q_status      q_stat;
    logic           push;
    logic           pop;
    logic [AW-1:0]  push_cx;
    logic [AW-1:0]  push_cy;
    logic [7:0]     push_hidx;
    logic [QW-1:0]  head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= RST_IMAGE_SIZE;
            r_scale      <= RST_SCALE_Q16;
            r_point_size <= RST_POINT_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data[10:0];
                REG_SCALE_Q16:  r_scale      <= i_cfg_data[23:0];
                REG_POINT_SIZE: r_point_size <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // saturate size and splat side to what the hardware is built for; a splat side of 0 counts as 1
    assign size = (32'(r_image_size) > 32'(MAX_IMAGE_SIZE)) ? SZW'(MAX_IMAGE_SIZE)
                                                            : SZW'(r_image_size);

    always_comb begin
        if (r_point_size == '0) begin
            ps = PSW'(1);
        end else if (r_point_size > 4'(MAX_SPLAT_SIZE)) begin
            ps = PSW'(MAX_SPLAT_SIZE);
        end else begin
            ps = PSW'(r_point_size);
        end
    end

    assign half    = ps >> 1;
    assign ps_last = CW'(ps - 1'b1);

    pbs_front #(
        .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
        .MAX_SPLAT_SIZE (MAX_SPLAT_SIZE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_size    (size),
        .i_scale   (r_scale),
        .i_half    (half),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_cx      (push_cx),
        .o_cy      (push_cy),
        .o_hidx    (push_hidx)
    );

    pbs_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cx, push_cy, push_hidx}),
        .i_pop   (pop),
        .o_data  (head),
        .o_stat  (q_stat)
    );

    pbs_back #(
        .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
        .MAX_SPLAT_SIZE (MAX_SPLAT_SIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_cx            (head[QW-1:AW+8]),
        .i_cy            (head[AW+7:8]),
        .i_hidx          (head[7:0]),
        .o_pop           (pop),
        .i_size          (size),
        .i_half          (half),
        .i_ps_last       (ps_last),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pixel_col     (o_pixel_col),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_address (o_pixel_address),
        .o_height_index  (o_height_index),
        .o_last_write    (o_last_write)
    );

`include "assert_macros.svh"

    // a splat never reaches past the image border
    `ASSERT_PROP(a_pixel_inside, o_valid |-> (o_pixel_col < size) && (o_pixel_row < size), "pixel outside image")
    // the rest of a splat is already queued in the sequencer when a word leaves
    `ASSERT_PROP(a_splat_continues, (o_valid && !i_stall && !o_last_write) |=> o_valid, "splat cut short")
    `ASSERT_NEVER(a_queue_status, q_stat.full && q_stat.empty, "queue full and empty")

endmodule
